/* rtl/rsdp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsdp_pkg: shared constants for the root pointer signature scanner
// Candidate geometry, signature bytes and parameter defaults.
// ----------------------------------------------------------------------------
package rsdp_pkg;

    // candidate geometry
    localparam int CAND_LEN  = 20;
    localparam int SIG_LEN   = 8;
    localparam int REV_INDEX = 15;

    // parameter defaults
    localparam int SCAN_STEP_DEFAULT   = 4;
    localparam int OFFSET_BITS_DEFAULT = 26;
    localparam int QUEUE_DEPTH         = 4;

    // "RSD PTR " in byte order
    localparam logic [7:0] RSDP_SIG [SIG_LEN] = '{
        8'h52, 8'h53, 8'h44, 8'h20, 8'h50, 8'h54, 8'h52, 8'h20
    };

endpackage

/* rtl/rsdp_ifs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsdp channel interfaces
// Byte input channel and result output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rsdp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       window_end;

    modport source (output valid, output data_byte, output window_end, input ready);
    modport sink   (input valid, input data_byte, input window_end, output ready);
endinterface

interface rsdp_result_if #(
    parameter int OFFSET_BITS = 26
);
    logic                   valid;
    logic                   ready;
    logic                   found;
    logic [OFFSET_BITS-1:0] struct_offset;
    logic [7:0]             revision;

    modport source (output valid, output found, output struct_offset, output revision,
                    input ready);
    modport sink   (input valid, input found, input struct_offset, input revision,
                    output ready);
endinterface

/* rtl/rsdp_signature_scanner_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsdp_signature_scanner_top: root pointer signature scanner
// Streams a memory window byte by byte and reports the first valid
// root pointer structure, or its absence at the window end.
//
//   channel  dir  handshake     payload
//   in_ch    in   valid/ready   data_byte[7:0], window_end
//   out_ch   out  valid/ready   found, struct_offset[OFFSET_BITS-1:0], revision[7:0]
//
// one byte is taken every cycle while the result queue has room; judgement
// happens in the cycle the byte arrives and the result is written into the queue, from which it reaches out_ch.
// in_ch only stalls when the result queue (QUEUE_DEPTH words) is full.
// reset clears the window, sum, offset counter and queue at once.
// ----------------------------------------------------------------------------
module rsdp_signature_scanner_top
    import rsdp_pkg::*;
#(
    parameter int SCAN_STEP   = SCAN_STEP_DEFAULT,
    parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    rsdp_byte_if.sink     in_ch,
    rsdp_result_if.source out_ch
);

    logic                   q_full;
    logic                   q_push;
    logic                   q_found;
    logic [OFFSET_BITS-1:0] q_offset;
    logic [7:0]             q_revision;

    // intake and judgement
    rsdp_front #(
        .SCAN_STEP   (SCAN_STEP),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_found    (q_found),
        .q_offset   (q_offset),
        .q_revision (q_revision)
    );

    // result queue
    rsdp_queue #(
        .OFFSET_BITS (OFFSET_BITS),
        .DEPTH       (QUEUE_DEPTH)
    ) u_queue (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (q_push),
        .push_found    (q_found),
        .push_offset   (q_offset),
        .push_revision (q_revision),
        .full          (q_full),
        .out_ch        (out_ch)
    );

    // no push into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
        else $error("result pushed into full queue");

    // a result away from a window end must be a find
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && !in_ch.window_end) |-> q_found)
        else $error("not-found result before window end");

    // a not-found word carries zero offset and revision
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.found) |-> (out_ch.struct_offset == '0 &&
                                             out_ch.revision == 8'h00))
        else $error("not-found result with nonzero fields");

    // a found word never carries revision zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.found) |-> (out_ch.revision != 8'h00))
        else $error("found result with revision zero");

endmodule

/* rtl/rsdp_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsdp_front: byte intake and candidate judgement
// Keeps the 20-byte sliding window and its sum, judges each aligned
// candidate as its last byte arrives and pushes results into the queue.
// ----------------------------------------------------------------------------
module rsdp_front
    import rsdp_pkg::*;
#(
    parameter int SCAN_STEP   = SCAN_STEP_DEFAULT,
    parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    rsdp_byte_if.sink              in_ch,
    input  logic                   q_full,
    output logic                   q_push,
    output logic                   q_found,
    output logic [OFFSET_BITS-1:0] q_offset,
    output logic [7:0]             q_revision
);

    localparam int PH_W = (SCAN_STEP > 1) ? $clog2(SCAN_STEP) : 1;
    localparam logic [PH_W-1:0] PH_TARGET = PH_W'((CAND_LEN - 1) % SCAN_STEP);
    localparam logic [PH_W-1:0] PH_LAST   = PH_W'(SCAN_STEP - 1);
    localparam logic [OFFSET_BITS-1:0] POS_MAX  = '1;
    localparam logic [OFFSET_BITS-1:0] POS_JUDGE = OFFSET_BITS'(CAND_LEN - 1);

    logic [7:0]             win_reg [CAND_LEN];
    logic [7:0]             sum_reg;
    logic [7:0]             sum_next;
    logic [OFFSET_BITS-1:0] pos_reg;
    logic [PH_W-1:0]        phase_reg;
    logic                   done_reg;
    logic                   accept;
    logic                   sig_ok;
    logic                   hit;

    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && in_ch.ready;

    // sum of the window after this word slides in
    assign sum_next = sum_reg - win_reg[0] + in_ch.data_byte;

    // signature over the first eight bytes of the shifted window
    always_comb
    begin
        sig_ok = 1'b1;
        for (int i = 0; i < SIG_LEN; i++)
        begin
            if (win_reg[i+1] != RSDP_SIG[i])
                sig_ok = 1'b0;
        end
    end

    // candidate judgement on its final byte
    assign hit = !done_reg && (pos_reg != POS_MAX) && (pos_reg >= POS_JUDGE) &&
                 (phase_reg == PH_TARGET) && sig_ok && (sum_next == 8'h00) &&
                 (win_reg[REV_INDEX+1] != 8'h00);

    // result word towards the queue
    assign q_push     = accept && (hit || (in_ch.window_end && !done_reg));
    assign q_found    = hit;
    assign q_offset   = hit ? (pos_reg - POS_JUDGE) : '0;
    assign q_revision = hit ? win_reg[REV_INDEX+1] : 8'h00;

    // window state, cleared at each window end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CAND_LEN; i++)
                win_reg[i] <= 8'h00;
            sum_reg   <= 8'h00;
            pos_reg   <= '0;
            phase_reg <= '0;
            done_reg  <= 1'b0;
        end
        else if (accept)
        begin
            if (in_ch.window_end)
            begin
                for (int i = 0; i < CAND_LEN; i++)
                    win_reg[i] <= 8'h00;
                sum_reg   <= 8'h00;
                pos_reg   <= '0;
                phase_reg <= '0;
                done_reg  <= 1'b0;
            end
            else
            begin
                for (int i = 0; i < CAND_LEN - 1; i++)
                    win_reg[i] <= win_reg[i+1];
                win_reg[CAND_LEN-1] <= in_ch.data_byte;
                sum_reg <= sum_next;
                if (pos_reg != POS_MAX)
                    pos_reg <= pos_reg + 1'b1;
                phase_reg <= (phase_reg == PH_LAST) ? '0 : phase_reg + 1'b1;
                if (hit)
                    done_reg <= 1'b1;
            end
        end
    end

endmodule

/* rtl/rsdp_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsdp_queue: result queue and output side
// Short first-in first-out store between judgement and the result channel.
// ----------------------------------------------------------------------------
module rsdp_queue
    import rsdp_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT,
    parameter int DEPTH       = QUEUE_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic                   push_found,
    input  logic [OFFSET_BITS-1:0] push_offset,
    input  logic [7:0]             push_revision,
    output logic                   full,
    rsdp_result_if.source          out_ch
);

    localparam int W     = 1 + OFFSET_BITS + 8;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [W-1:0]     mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             pop;
    logic [W-1:0]     head;

    assign full         = (count_reg == CNT_FULL);
    assign pop          = out_ch.valid && out_ch.ready;
    assign head         = mem_reg[rd_ptr_reg];
    assign out_ch.valid = (count_reg != '0);
    assign out_ch.found         = head[W-1];
    assign out_ch.struct_offset = head[W-2:8];
    assign out_ch.revision      = head[7:0];

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= {push_found, push_offset, push_revision};
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule
